// ===== rtl/sgr_pkg.sv =====
// ----------------------------------------------------------------------------
// sgr_pkg: types and constants for the stereo gain ramp core
// Beat layouts, fixed-point widths, register indexes and target scaling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sgr_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int TARGET_BITS    = 16;
    localparam int GAIN_FRAC_BITS = 14;
    localparam int ACC_FRAC_BITS  = 30;
    localparam int GAIN_BITS      = 32;
    localparam int STEP_BITS      = GAIN_BITS + 1;
    localparam int LEN_BITS       = 16;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 1;
    localparam int TGT_SHIFT      = ACC_FRAC_BITS - GAIN_FRAC_BITS;

    localparam logic [LEN_BITS-1:0] RAMP_LEN_RESET = LEN_BITS'(441);

    localparam logic [CFG_INDEX_BITS-1:0] REG_RAMP_LENGTH = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MONO_MODE   = 1'b1;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_first;
        logic signed [SAMPLE_BITS-1:0] sample_second;
        logic        [TARGET_BITS-1:0] tgt_left;
        logic        [TARGET_BITS-1:0] tgt_right;
        logic                          block_start;
        logic                          restart;
    } sgr_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] out_left;
        logic signed [SAMPLE_BITS-1:0] out_right;
    } sgr_result_t;

    function automatic logic [GAIN_BITS-1:0] tgt_to_acc(input logic [TARGET_BITS-1:0] t);
        logic [63:0] w;
        w = 64'(t) << TGT_SHIFT;
        if (w > 64'({GAIN_BITS{1'b1}}))
            return {GAIN_BITS{1'b1}};
        return w[GAIN_BITS-1:0];
    endfunction

endpackage

// ===== rtl/stereo_gain_ramp_core.sv =====
// Per item, with block_start, two passes of the shared 2-bit-per-cycle divider
// (16 iterations each) set the left, then the right step; then gain advance, multiply
// and saturate per channel; S_DONE waits on a stalled result; new items wait for idle.
// One shared 16x32 multiplier serves both channels in turn.
// Reset: gains and steps zero, ramp_length 441, mono_mode 0, no result pending.
// ----------------------------------------------------------------------------
// stereo_gain_ramp_core: per-channel ramped gain with saturation
// Sequencer around a shared divider, adder/clamp and multiplier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stereo_gain_ramp_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write_en,
    input  logic [sgr_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [sgr_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  logic                                 item_valid,
    output logic                                 item_stall,
    input  sgr_pkg::sgr_item_t                   item,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output sgr_pkg::sgr_result_t                 result
);
    import sgr_pkg::*;

    localparam int PROD_BITS     = SAMPLE_BITS + GAIN_BITS;
    localparam int SHR_BITS      = PROD_BITS - ACC_FRAC_BITS;
    localparam int DIV_STEPS     = GAIN_BITS / 2;
    localparam int DIV_CNT_BITS  = $clog2(DIV_STEPS);

    localparam logic [DIV_CNT_BITS-1:0] DIV_LAST = DIV_CNT_BITS'(DIV_STEPS - 1);
    localparam logic [SHR_BITS-1:0] SAT_POS = SHR_BITS'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
    localparam logic [SHR_BITS-1:0] SAT_NEG = SHR_BITS'(64'd1 << (SAMPLE_BITS - 1));
    localparam logic [SAMPLE_BITS-1:0] OUT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] OUT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DSET = 3'd1;
    localparam logic [2:0] S_DRUN = 3'd2;
    localparam logic [2:0] S_ADV  = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_SAT  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]                    state_reg, state_next;
    logic                          chan_reg, chan_next;
    logic [LEN_BITS-1:0]           ramp_length_reg, ramp_length_next;
    logic                          mono_mode_reg, mono_mode_next;
    logic [GAIN_BITS-1:0]          gain_l_reg, gain_l_next;
    logic [GAIN_BITS-1:0]          gain_r_reg, gain_r_next;
    logic signed [STEP_BITS-1:0]   step_l_reg, step_l_next;
    logic signed [STEP_BITS-1:0]   step_r_reg, step_r_next;
    logic [DIV_CNT_BITS-1:0]       div_cnt_reg, div_cnt_next;
    logic                          result_valid_reg, result_valid_next;

    logic signed [SAMPLE_BITS-1:0] samp_l_reg, samp_l_next;
    logic signed [SAMPLE_BITS-1:0] samp_r_reg, samp_r_next;
    logic [GAIN_BITS-1:0]          tgt_l_reg, tgt_l_next;
    logic [GAIN_BITS-1:0]          tgt_r_reg, tgt_r_next;
    logic [GAIN_BITS-1:0]          div_num_reg, div_num_next;
    logic [LEN_BITS-1:0]           div_rem_reg, div_rem_next;
    logic                          div_neg_reg, div_neg_next;
    logic [PROD_BITS-1:0]          prod_reg, prod_next;
    logic [SAMPLE_BITS-1:0]        res_l_reg, res_l_next;
    logic [SAMPLE_BITS-1:0]        res_r_reg, res_r_next;
    sgr_result_t                   result_reg, result_next;

    logic                          accept;
    logic [GAIN_BITS-1:0]          cur_gain;
    logic [GAIN_BITS-1:0]          cur_tgt;
    logic signed [STEP_BITS-1:0]   cur_step;
    logic signed [SAMPLE_BITS-1:0] cur_samp;
    logic [LEN_BITS-1:0]           len_eff;
    logic signed [STEP_BITS-1:0]   diff;
    logic [GAIN_BITS-1:0]          diff_mag;
    logic [LEN_BITS:0]             trial1, trial2;
    logic                          q1, q2;
    logic [LEN_BITS-1:0]           rem1, rem2;
    logic [GAIN_BITS-1:0]          quot;
    logic signed [STEP_BITS-1:0]   new_step;
    logic signed [GAIN_BITS+1:0]   sum;
    logic [GAIN_BITS-1:0]          sum_clamp;
    logic [GAIN_BITS-1:0]          adv_gain;
    logic                          step_pos, step_neg;
    logic [SAMPLE_BITS-1:0]        samp_mag;
    logic [SHR_BITS-1:0]           shr;
    logic [SAMPLE_BITS-1:0]        sat_val;

    assign accept       = item_valid && !item_stall;
    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign cur_gain = chan_reg ? gain_r_reg : gain_l_reg;
    assign cur_tgt  = chan_reg ? tgt_r_reg  : tgt_l_reg;
    assign cur_step = chan_reg ? step_r_reg : step_l_reg;
    assign cur_samp = chan_reg ? samp_r_reg : samp_l_reg;
    assign len_eff  = (ramp_length_reg == '0) ? LEN_BITS'(1) : ramp_length_reg;

    // divider set-up
    assign diff     = $signed({1'b0, cur_tgt}) - $signed({1'b0, cur_gain});
    assign diff_mag = diff[STEP_BITS-1] ? GAIN_BITS'(-diff) : diff[GAIN_BITS-1:0];

    // two restoring steps per cycle
    always_comb
    begin
        trial1 = {div_rem_reg, div_num_reg[GAIN_BITS-1]};
        q1     = (trial1 >= {1'b0, len_eff});
        rem1   = q1 ? LEN_BITS'(trial1 - {1'b0, len_eff}) : trial1[LEN_BITS-1:0];
        trial2 = {rem1, div_num_reg[GAIN_BITS-2]};
        q2     = (trial2 >= {1'b0, len_eff});
        rem2   = q2 ? LEN_BITS'(trial2 - {1'b0, len_eff}) : trial2[LEN_BITS-1:0];
        quot   = {div_num_reg[GAIN_BITS-3:0], q1, q2};
        new_step = div_neg_reg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    end

    // gain advance with clamp
    always_comb
    begin
        sum      = $signed({2'b00, cur_gain}) + $signed({cur_step[STEP_BITS-1], cur_step});
        step_pos = !cur_step[STEP_BITS-1] && (cur_step != '0);
        step_neg = cur_step[STEP_BITS-1];
        if (sum[GAIN_BITS+1])
            sum_clamp = '0;
        else if (sum[GAIN_BITS])
            sum_clamp = {GAIN_BITS{1'b1}};
        else
            sum_clamp = sum[GAIN_BITS-1:0];
        if ((step_pos && sum_clamp > cur_tgt) || (step_neg && sum_clamp < cur_tgt))
            adv_gain = cur_tgt;
        else
            adv_gain = sum_clamp;
    end

    // multiply and saturate
    always_comb
    begin
        samp_mag = cur_samp[SAMPLE_BITS-1] ? SAMPLE_BITS'(-cur_samp) : SAMPLE_BITS'(cur_samp);
        shr      = prod_reg[PROD_BITS-1:ACC_FRAC_BITS];
        if (!cur_samp[SAMPLE_BITS-1])
            sat_val = (shr > SAT_POS) ? OUT_MAX : shr[SAMPLE_BITS-1:0];
        else
            sat_val = (shr > SAT_NEG) ? OUT_MIN : SAMPLE_BITS'(-shr[SAMPLE_BITS-1:0]);
    end

    always_comb
    begin
        state_next        = state_reg;
        chan_next         = chan_reg;
        ramp_length_next  = ramp_length_reg;
        mono_mode_next    = mono_mode_reg;
        gain_l_next       = gain_l_reg;
        gain_r_next       = gain_r_reg;
        step_l_next       = step_l_reg;
        step_r_next       = step_r_reg;
        div_cnt_next      = div_cnt_reg;
        result_valid_next = result_valid_reg;
        samp_l_next       = samp_l_reg;
        samp_r_next       = samp_r_reg;
        tgt_l_next        = tgt_l_reg;
        tgt_r_next        = tgt_r_reg;
        div_num_next      = div_num_reg;
        div_rem_next      = div_rem_reg;
        div_neg_next      = div_neg_reg;
        prod_next         = prod_reg;
        res_l_next        = res_l_reg;
        res_r_next        = res_r_reg;
        result_next       = result_reg;

        if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_RAMP_LENGTH: ramp_length_next = cfg_data[LEN_BITS-1:0];
                REG_MONO_MODE:   mono_mode_next   = cfg_data[0];
            endcase
        end

        if (result_valid_reg && !result_stall)
            result_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    samp_l_next = item.sample_first;
                    samp_r_next = mono_mode_reg ? item.sample_first : item.sample_second;
                    tgt_l_next  = tgt_to_acc(item.tgt_left);
                    tgt_r_next  = tgt_to_acc(item.tgt_right);
                    chan_next   = 1'b0;
                    if (item.restart)
                    begin
                        gain_l_next = '0;
                        gain_r_next = '0;
                    end
                    state_next = item.block_start ? S_DSET : S_ADV;
                end
            end
            S_DSET:
            begin
                div_num_next = diff_mag;
                div_rem_next = '0;
                div_neg_next = diff[STEP_BITS-1];
                div_cnt_next = '0;
                state_next   = S_DRUN;
            end
            S_DRUN:
            begin
                div_num_next = quot;
                div_rem_next = rem2;
                div_cnt_next = div_cnt_reg + DIV_CNT_BITS'(1);
                if (div_cnt_reg == DIV_LAST)
                begin
                    if (chan_reg)
                    begin
                        step_r_next = new_step;
                        chan_next   = 1'b0;
                        state_next  = S_ADV;
                    end
                    else
                    begin
                        step_l_next = new_step;
                        chan_next   = 1'b1;
                        state_next  = S_DSET;
                    end
                end
            end
            S_ADV:
            begin
                if (chan_reg)
                begin
                    gain_r_next = adv_gain;
                    chan_next   = 1'b0;
                    state_next  = S_MUL;
                end
                else
                begin
                    gain_l_next = adv_gain;
                    chan_next   = 1'b1;
                end
            end
            S_MUL:
            begin
                prod_next  = PROD_BITS'(samp_mag) * PROD_BITS'(cur_gain);
                state_next = S_SAT;
            end
            S_SAT:
            begin
                if (chan_reg)
                begin
                    res_r_next = sat_val;
                    chan_next  = 1'b0;
                    state_next = S_DONE;
                end
                else
                begin
                    res_l_next = sat_val;
                    chan_next  = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_DONE:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_next.out_left  = res_l_reg;
                    result_next.out_right = res_r_reg;
                    result_valid_next     = 1'b1;
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            chan_reg         <= 1'b0;
            ramp_length_reg  <= RAMP_LEN_RESET;
            mono_mode_reg    <= 1'b0;
            gain_l_reg       <= '0;
            gain_r_reg       <= '0;
            step_l_reg       <= '0;
            step_r_reg       <= '0;
            div_cnt_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            chan_reg         <= chan_next;
            ramp_length_reg  <= ramp_length_next;
            mono_mode_reg    <= mono_mode_next;
            gain_l_reg       <= gain_l_next;
            gain_r_reg       <= gain_r_next;
            step_l_reg       <= step_l_next;
            step_r_reg       <= step_r_next;
            div_cnt_reg      <= div_cnt_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        samp_l_reg  <= samp_l_next;
        samp_r_reg  <= samp_r_next;
        tgt_l_reg   <= tgt_l_next;
        tgt_r_reg   <= tgt_r_next;
        div_num_reg <= div_num_next;
        div_rem_reg <= div_rem_next;
        div_neg_reg <= div_neg_next;
        prod_reg    <= prod_next;
        res_l_reg   <= res_l_next;
        res_r_reg   <= res_r_next;
        result_reg  <= result_next;
    end

`ifndef NO_ASSERTIONS
    a_plain_item_skips_divide: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !item.block_start |=> state_reg == S_ADV && !chan_reg)
        else $error("item without block start did not go to gain advance");

    a_block_start_divides: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.block_start |=> state_reg == S_DSET && !chan_reg)
        else $error("block start did not enter divider set-up");

    a_restart_zeroes_gains: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.restart |=> gain_l_reg == '0 && gain_r_reg == '0)
        else $error("restart did not clear gains");

    a_divide_ends: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DRUN && div_cnt_reg == DIV_LAST
        |=> state_reg == S_DSET || state_reg == S_ADV)
        else $error("divider overran its iteration count");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("result beat raised outside completion");
`endif

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for stereo_gain_ramp_core
// Queues directed and random beats through a bursty driver, predicts each
// result with an in-bench gain ramp model, and checks every result beat in
// order against a receiver that stalls on its own changing pattern.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    import sgr_pkg::*;

    localparam longint GAIN_MAX = 64'h0000_0000_FFFF_FFFF;
    localparam longint OUT_HI   = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint OUT_LO   = -OUT_HI - 1;

    logic                       clk          = 1'b0;
    logic                       rst_n        = 1'b0;
    logic                       cfg_write_en = 1'b0;
    logic [CFG_INDEX_BITS-1:0]  cfg_index    = '0;
    logic [CFG_DATA_BITS-1:0]   cfg_data     = '0;
    logic                       item_valid   = 1'b0;
    logic                       item_stall;
    sgr_item_t                  item         = '0;
    logic                       result_valid;
    logic                       result_stall = 1'b0;
    sgr_result_t                result;

    sgr_item_t                  pending_beats[$];
    sgr_result_t                expected_out[$];

    logic [GAIN_BITS-1:0]       gain_l_q = '0;
    logic [GAIN_BITS-1:0]       gain_r_q = '0;
    longint                     step_l_q = 0;
    longint                     step_r_q = 0;
    logic [LEN_BITS-1:0]        ramp_len_q = RAMP_LEN_RESET;
    logic                       mono_q = 1'b0;

    int                         burst_left = 1;
    int                         gap_left = 0;
    int                         stall_mode = 0;
    int                         mode_left = 0;
    int                         stall_left = 0;

    int                         error_count = 0;
    int                         n_beats = 0;
    int                         n_results = 0;
    int                         n_blocks = 0;
    int                         n_restarts = 0;
    int                         n_railed = 0;
    int                         n_settings = 1;

    stereo_gain_ramp_core u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #6 clk = ~clk;

    function automatic logic [GAIN_BITS-1:0] target_gain(logic [TARGET_BITS-1:0] t);
        longint w;
        w = longint'({48'h0, t}) << TGT_SHIFT;
        if (w > GAIN_MAX)
            w = GAIN_MAX;
        return w[GAIN_BITS-1:0];
    endfunction

    function automatic longint ramp_step(logic [GAIN_BITS-1:0] tgt, logic [GAIN_BITS-1:0] cur);
        longint len;
        len = (ramp_len_q == '0) ? 64'sd1 : longint'({48'h0, ramp_len_q});
        return (longint'({32'h0, tgt}) - longint'({32'h0, cur})) / len;
    endfunction

    function automatic logic [GAIN_BITS-1:0] stepped_gain(logic [GAIN_BITS-1:0] cur,
                                                          longint step,
                                                          logic [GAIN_BITS-1:0] tgt);
        longint nv;
        longint lim;
        nv  = longint'({32'h0, cur}) + step;
        lim = longint'({32'h0, tgt});
        if (nv < 0)
            nv = 0;
        if (nv > GAIN_MAX)
            nv = GAIN_MAX;
        if ((step > 0 && nv > lim) || (step < 0 && nv < lim))
            nv = lim;
        return nv[GAIN_BITS-1:0];
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] scaled_sample(
        logic signed [SAMPLE_BITS-1:0] s, logic [GAIN_BITS-1:0] g);
        longint mag;
        longint r;
        mag = (s < 0) ? -longint'(s) : longint'(s);
        mag = (mag * longint'({32'h0, g})) >>> ACC_FRAC_BITS;
        r   = (s < 0) ? -mag : mag;
        if (r > OUT_HI)
            r = OUT_HI;
        if (r < OUT_LO)
            r = OUT_LO;
        return r[SAMPLE_BITS-1:0];
    endfunction

    task automatic predict_beat(sgr_item_t it);
        logic signed [SAMPLE_BITS-1:0] left_in;
        logic signed [SAMPLE_BITS-1:0] right_in;
        logic [GAIN_BITS-1:0]          tl;
        logic [GAIN_BITS-1:0]          tr;
        sgr_result_t                   r;
        left_in  = it.sample_first;
        right_in = mono_q ? it.sample_first : it.sample_second;
        tl = target_gain(it.tgt_left);
        tr = target_gain(it.tgt_right);
        if (it.restart)
        begin
            gain_l_q = '0;
            gain_r_q = '0;
            n_restarts++;
        end
        if (it.block_start)
        begin
            step_l_q = ramp_step(tl, gain_l_q);
            step_r_q = ramp_step(tr, gain_r_q);
            n_blocks++;
        end
        gain_l_q = stepped_gain(gain_l_q, step_l_q, tl);
        gain_r_q = stepped_gain(gain_r_q, step_r_q, tr);
        r.out_left  = scaled_sample(left_in, gain_l_q);
        r.out_right = scaled_sample(right_in, gain_r_q);
        if (r.out_left == OUT_HI[SAMPLE_BITS-1:0] || r.out_left == OUT_LO[SAMPLE_BITS-1:0])
            n_railed++;
        if (r.out_right == OUT_HI[SAMPLE_BITS-1:0] || r.out_right == OUT_LO[SAMPLE_BITS-1:0])
            n_railed++;
        expected_out = {expected_out, r};
        n_beats++;
    endtask

    // Driver: bursts of beats with random gaps between them
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item       <= '0;
        end
        else
        begin
            if (item_valid && !item_stall)
                predict_beat(item);
            if (!item_valid || !item_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    item_valid <= 1'b0;
                end
                else if (pending_beats.size() > 0)
                begin
                    item       <= pending_beats.pop_front();
                    item_valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 50);
                    end
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // Monitor: stall on a shifting pattern, check each result beat in order
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (result_valid && !result_stall)
            begin
                n_results++;
                if (expected_out.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 40)
                        $display("%0t: unexpected result beat, expected none, actual %0d/%0d",
                                 $time, result.out_left, result.out_right);
                end
                else
                begin
                    if (result.out_left !== expected_out[0].out_left)
                    begin
                        error_count++;
                        if (error_count <= 40)
                            $display("%0t: out_left mismatch, expected %0d, actual %0d",
                                     $time, expected_out[0].out_left, result.out_left);
                    end
                    if (result.out_right !== expected_out[0].out_right)
                    begin
                        error_count++;
                        if (error_count <= 40)
                            $display("%0t: out_right mismatch, expected %0d, actual %0d",
                                     $time, expected_out[0].out_right, result.out_right);
                    end
                    void'(expected_out.pop_front());
                end
            end
            if (mode_left <= 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(50, 600);
            end
            mode_left--;
            if (stall_left > 0)
            begin
                stall_left--;
                result_stall <= 1'b1;
            end
            else
            begin
                case (stall_mode)
                    0: result_stall <= 1'b0;
                    1: result_stall <= ($urandom_range(0, 3) == 0);
                    2: result_stall <= ($urandom_range(0, 3) != 0);
                    default:
                    begin
                        if ($urandom_range(0, 7) == 0)
                            stall_left = $urandom_range(5, 80);
                        result_stall <= (stall_left > 0);
                    end
                endcase
            end
        end
    end

    function automatic sgr_item_t make_beat(int s1, int s2, logic [TARGET_BITS-1:0] tl,
                                            logic [TARGET_BITS-1:0] tr, logic bs, logic rs);
        sgr_item_t it;
        it.sample_first  = SAMPLE_BITS'(s1);
        it.sample_second = SAMPLE_BITS'(s2);
        it.tgt_left      = tl;
        it.tgt_right     = tr;
        it.block_start   = bs;
        it.restart       = rs;
        return it;
    endfunction

    task automatic queue_beat(sgr_item_t it);
        pending_beats = {pending_beats, it};
    endtask

    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return SAMPLE_BITS'(OUT_HI);
            1: return SAMPLE_BITS'(OUT_LO);
            2: return SAMPLE_BITS'($signed($urandom_range(0, 8)) - 4);
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [TARGET_BITS-1:0] pick_target();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return TARGET_BITS'(1 << GAIN_FRAC_BITS);
            default: return TARGET_BITS'($urandom);
        endcase
    endfunction

    task automatic wait_drained();
        @(negedge clk);
        while (pending_beats.size() > 0 || item_valid || expected_out.size() > 0)
            @(negedge clk);
    endtask

    task automatic program_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        case (idx)
            REG_RAMP_LENGTH: ramp_len_q = val;
            REG_MONO_MODE:   mono_q = val[0];
            default: ;
        endcase
    endtask

    task automatic run_setting(logic [LEN_BITS-1:0] len, logic mono, int count);
        int                     blk_left;
        logic [TARGET_BITS-1:0] tl;
        logic [TARGET_BITS-1:0] tr;
        logic                   bs;
        wait_drained();
        program_reg(REG_RAMP_LENGTH, len);
        program_reg(REG_MONO_MODE, {(CFG_DATA_BITS-1)'($urandom), mono});
        n_settings++;
        blk_left = 0;
        tl = pick_target();
        tr = pick_target();
        for (int i = 0; i < count; i++)
        begin
            bs = 1'b0;
            if (blk_left <= 0)
            begin
                bs       = 1'b1;
                blk_left = $urandom_range(1, 24);
                tl       = pick_target();
                tr       = pick_target();
            end
            else
            begin
                if ($urandom_range(0, 15) == 0)
                    tl = pick_target();
                if ($urandom_range(0, 15) == 0)
                    tr = pick_target();
                if ($urandom_range(0, 29) == 0)
                    bs = 1'b1;
            end
            blk_left--;
            queue_beat(make_beat(pick_sample(), pick_sample(), tl, tr, bs,
                                 $urandom_range(0, 19) == 0));
        end
    endtask

    initial
    begin
        #12_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: slow ramp, stereo
        queue_beat(make_beat(32767, -32768, '1, '1, 1'b1, 1'b0));
        queue_beat(make_beat(-32768, 32767, '1, '1, 1'b0, 1'b0));
        queue_beat(make_beat(12000, -12000, '1, '1, 1'b0, 1'b1));

        wait_drained();
        program_reg(REG_RAMP_LENGTH, 16'd1);
        n_settings++;
        queue_beat(make_beat(32767, -32768, '1, '1, 1'b1, 1'b1));
        queue_beat(make_beat(1, -1, '1, '1, 1'b0, 1'b0));
        queue_beat(make_beat(0, 0, '1, '1, 1'b0, 1'b0));
        queue_beat(make_beat(-32768, 32767, 16'h4000, 16'h4000, 1'b1, 1'b0));
        queue_beat(make_beat(-3, 3, 16'h2000, 16'h6000, 1'b1, 1'b0));
        queue_beat(make_beat(100, 100, 16'h2000, 16'h6000, 1'b0, 1'b1));
        queue_beat(make_beat(-7, 7, 16'h1000, 16'h3000, 1'b0, 1'b0));
        queue_beat(make_beat(5, -5, 16'h1000, 16'h3000, 1'b1, 1'b0));
        queue_beat(make_beat(16384, -16384, 16'h0000, 16'hFFFF, 1'b0, 1'b0));
        queue_beat(make_beat(32767, 32767, 16'h0000, 16'h0000, 1'b1, 1'b0));
        queue_beat(make_beat(-1, 32767, 16'hFFFF, 16'h0001, 1'b1, 1'b1));

        wait_drained();
        program_reg(REG_RAMP_LENGTH, 16'd3);
        n_settings++;
        queue_beat(make_beat(-32768, 32767, 16'h0001, 16'h0000, 1'b1, 1'b0));
        queue_beat(make_beat(-20001, 20001, 16'h0001, 16'h0000, 1'b0, 1'b0));

        // hold the sender until the pipe is empty before switching to mono
        wait_drained();
        program_reg(REG_MONO_MODE, 16'hFFFF);
        n_settings++;
        queue_beat(make_beat(-20000, 12345, 16'h4000, 16'h8000, 1'b1, 1'b0));
        queue_beat(make_beat(32767, -32768, 16'h4000, 16'h8000, 1'b0, 1'b0));
        queue_beat(make_beat(-32768, 0, 16'hFFFF, 16'h0000, 1'b1, 1'b1));

        run_setting(16'd1, 1'b0, 120);
        run_setting(16'd0, 1'b1, 100);
        run_setting(16'd8, 1'b0, 180);
        run_setting(16'hFFFF, 1'b0, 80);
        run_setting(LEN_BITS'($urandom_range(2, 40)), 1'b1, 160);
        run_setting(RAMP_LEN_RESET, 1'b0, 160);
        run_setting(LEN_BITS'($urandom_range(2, 300)), 1'b0, 160);
        run_setting(16'd3, 1'b1, 170);

        wait_drained();
        repeat (64) @(posedge clk);

        $display("Run covered %0d beats and %0d results over %0d register settings,",
                 n_beats, n_results, n_settings);
        $display("with %0d block starts, %0d restarts and %0d outputs on the rails.",
                 n_blocks, n_restarts, n_railed);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== stereo_gain_ramp_core.f =====
rtl/sgr_pkg.sv
rtl/stereo_gain_ramp_core.sv
verif/testbench.sv
